@@ design/assert_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define PSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("psc assertion failed");

// Property that must hold whenever the condition holds.
`define PSC_ASSERT_IF(lbl, cond, prop) \
  `PSC_ASSERT(lbl, (cond) |-> (prop))

`endif

@@ design/psc_pkg.sv @@
package psc_pkg;

  localparam int CW    = 16;          // coordinate width, Q12.4
  localparam int DW    = CW + 1;      // coordinate difference
  localparam int PW    = 2 * DW;      // product of two differences
  localparam int SW    = PW + 1;      // sum of two products
  localparam int FB    = 16;          // fraction bits of t
  localparam int TW    = 32;          // t width, Q16.16
  localparam int QW    = TW + 1;      // quotient bits resolved by the divider
  localparam int NW    = SW + FB + 1; // dividend width
  localparam int RW    = SW + 1;      // partial remainder width
  localparam int MW    = DW + TW;     // difference times t
  localparam int RDW   = MW - FB + 1; // rounded offset along the line
  localparam int NSW   = RDW + 1;     // start point plus offset
  localparam int DISTW = 17;          // distance width, Q13.4
  localparam int SQN   = (SW + 1) / 2; // root bits, one per stage
  localparam int SQW   = 2 * SQN + 1; // root datapath width
  localparam int CIW   = 4;           // config index width

  typedef enum logic [CIW-1:0] {
    REG_SX = 4'd0,
    REG_SY = 4'd1,
    REG_EX = 4'd2,
    REG_EY = 4'd3
  } cfg_reg_e;

  // Per-word context carried alongside the divider.
  typedef struct packed {
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 clamp;
    logic                 neg;
    logic                 zero;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
  } near_t;

endpackage

@@ design/psc_div.sv @@
`include "assert_macros.svh"

module psc_div import psc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [SW-1:0] den_i,
  input  side_t         side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output side_t         side_o
);

  logic          v_q   [QW+1];
  logic [RW-1:0] rem_q [QW+1];
  logic [QW-1:0] num_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [SW-1:0] den_q [QW+1];
  logic          ovf_q [QW+1];
  side_t         side_q [QW+1];

  logic [RW-1:0] rem_init;

  // The high dividend bits start the remainder; if they already reach the
  // divisor the quotient needs more than QW bits.
  assign rem_init = RW'(num_i[NW-1:QW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_init;
      num_q[0]  <= num_i[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= rem_init >= {1'b0, den_i};
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = {rem_q[k][RW-2:0], num_q[k][QW-1-k]};
      ge    = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? trial - {1'b0, den_q[k]} : trial;
        num_q[k+1]  <= num_q[k];
        quo_q[k+1]  <= {quo_q[k][QW-2:0], ge};
        den_q[k+1]  <= den_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

  `PSC_ASSERT_IF(a_div_rem, v_q[QW] && !ovf_q[QW] && den_q[QW] != '0,
                 rem_q[QW] < {1'b0, den_q[QW]})

endmodule

@@ design/psc_sqrt.sv @@
`include "assert_macros.svh"

module psc_sqrt import psc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SW-1:0]    sq_i,
  input  near_t            near_i,
  output logic             valid_o,
  output logic [DISTW-1:0] dist_o,
  output near_t            near_o
);

  localparam logic [SQW-1:0] DMAX = SQW'((1 << DISTW) - 1);

  logic           v_q    [SQN+1];
  logic [SQW-1:0] n_q    [SQN+1];
  logic [SQW-1:0] r_q    [SQN+1];
  near_t          near_q [SQN+1];

  logic             out_v_q;
  logic [DISTW-1:0] dist_q;
  near_t            out_near_q;
  logic [SQW-1:0]   r_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= SQW'(sq_i);
      r_q[0]    <= '0;
      near_q[0] <= near_i;
    end
  end

  for (genvar k = 0; k < SQN; k++) begin : g_stage
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQN - 1 - k));
    logic [SQW-1:0] trial;
    logic           ge;

    always_comb begin
      trial = r_q[k] + BIT;
      ge    = n_q[k] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]    <= ge ? n_q[k] - trial : n_q[k];
        r_q[k+1]    <= ge ? (r_q[k] >> 1) + BIT : r_q[k] >> 1;
        near_q[k+1] <= near_q[k];
      end
    end
  end

  // Round up when the leftover exceeds the root.
  assign r_fin = r_q[SQN] + SQW'(n_q[SQN] > r_q[SQN]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[SQN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q     <= (r_fin > DMAX) ? DMAX[DISTW-1:0] : r_fin[DISTW-1:0];
      out_near_q <= near_q[SQN];
    end
  end

  assign valid_o = out_v_q;
  assign dist_o  = dist_q;
  assign near_o  = out_near_q;

  `PSC_ASSERT_IF(a_sqrt_rem, v_q[SQN], n_q[SQN] <= (r_q[SQN] << 1))

endmodule

@@ design/point_segment_closest_point_unit.sv @@
// Closest point on a configured line or segment, with distance to the query.
// Each accepted word passes the front stages, the 34-stage restoring divider
// (an input register, then one quotient bit a stage), the back stages and the 20-stage square root.
// Throughput: one word per cycle while the skid register is empty; a stalled
// result parks in that output skid register while the pipeline holds. Reset
// clears all valid bits and the four line registers to zero.
`include "assert_macros.svh"

module point_segment_closest_point_unit import psc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CW-1:0]    point_x_i,
  input  logic signed [CW-1:0]    point_y_i,
  input  logic                    clamp_to_segment_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [CW-1:0]    near_x_o,
  output logic signed [CW-1:0]    near_y_o,
  output logic [DISTW-1:0]        distance_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CIW-1:0]          cfg_index_i,
  input  logic [CW-1:0]           cfg_data_i
);

  localparam logic signed [TW-1:0]  T_MAX   = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0]  T_MIN   = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0]  T_ONE   = TW'(1 << FB);
  localparam logic [QW-1:0]         Q_NEG   = QW'(1) << (TW - 1);
  localparam logic signed [MW-1:0]  HALF    = MW'(1) << (FB - 1);
  localparam logic signed [NSW-1:0] C_MAX   = NSW'((1 << (CW - 1)) - 1);
  localparam logic signed [NSW-1:0] C_MIN   = -C_MAX - NSW'(1);

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [NSW-1:0] v);
    if (v > C_MAX) begin
      return C_MAX[CW-1:0];
    end else if (v < C_MIN) begin
      return C_MIN[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // line registers
  logic signed [CW-1:0] sx_q, sy_q, ex_q, ey_q;

  logic en;

  // stage 1: differences
  logic                 v1_q;
  side_t                s1_q;
  logic signed [DW-1:0] vx1_q, vy1_q;
  // stage 2: products
  logic                 v2_q;
  side_t                s2_q;
  logic signed [PW-1:0] pxx_q, pyy_q, pvx_q, pvy_q;
  // stage 3: squared length and dot product
  logic                 v3_q;
  side_t                s3_q;
  logic [SW-1:0]        l2_3_q;
  logic signed [SW-1:0] dot_q;
  // stage 4: magnitude of the dot product
  logic                 v4_q;
  side_t                s4_q;
  side_t                s4_d;
  logic [SW-1:0]        l2_4_q;
  logic [SW-1:0]        mag_q;
  // stage 5: dividend with half divisor for rounding
  logic                 v5_q;
  side_t                s5_q;
  logic [SW-1:0]        l2_5_q;
  logic [NW-1:0]        num_q;
  // divider outputs
  logic                 vd;
  logic [QW-1:0]        quo;
  logic                 ovf;
  side_t                sd;
  // stage 6: t
  logic                 v6_q;
  side_t                s6_q;
  logic signed [TW-1:0] t_q;
  logic signed [TW-1:0] t_d;
  // stage 7: offsets
  logic                 v7_q;
  side_t                s7_q;
  logic signed [MW-1:0] mx_q, my_q;
  // stage 8: rounded offsets
  logic                 v8_q;
  side_t                s8_q;
  logic signed [RDW-1:0] rx_q, ry_q;
  logic signed [MW-1:0]  rx_sum, ry_sum;
  // stage 9: closest point
  logic                 v9_q;
  logic signed [CW-1:0] qx9_q, qy9_q;
  near_t                n9_q;
  // stage 10: error vector
  logic                 v10_q;
  near_t                n10_q;
  logic signed [DW-1:0] erx_q, ery_q;
  // stage 11: squared errors
  logic                 v11_q;
  near_t                n11_q;
  logic [PW-1:0]        sqx_q, sqy_q;
  // root outputs and skid
  logic                 vr;
  logic [DISTW-1:0]     dist_r;
  near_t                near_r;
  logic                 skid_v_q;
  logic [DISTW-1:0]     skid_dist_q;
  near_t                skid_near_q;

  // pipeline holds only while the skid register is occupied
  assign en          = !skid_v_q;
  assign in_stall_o  = skid_v_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      ex_q <= '0;
      ey_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SX: sx_q <= cfg_data_i;
        REG_SY: sy_q <= cfg_data_i;
        REG_EX: ex_q <= cfg_data_i;
        REG_EY: ey_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= vd;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  // tag sign of the dot product and a zero-length line
  always_comb begin
    s4_d      = s3_q;
    s4_d.neg  = dot_q[SW-1];
    s4_d.zero = l2_3_q == '0;
  end

  // t from the quotient: sign, saturation, zero-length case, optional clamp
  always_comb begin
    if (sd.zero) begin
      t_d = '0;
    end else if (sd.neg) begin
      t_d = (ovf || quo > Q_NEG) ? T_MIN : TW'(0) - $signed(quo[TW-1:0]);
    end else begin
      t_d = (ovf || quo > QW'(T_MAX)) ? T_MAX : $signed(quo[TW-1:0]);
    end
    if (sd.clamp) begin
      if (t_d[TW-1]) begin
        t_d = '0;
      end else if (t_d > T_ONE) begin
        t_d = T_ONE;
      end
    end
  end

  // round half away from zero: negative values take half minus one
  assign rx_sum = (mx_q + (mx_q[MW-1] ? HALF - MW'(1) : HALF)) >>> FB;
  assign ry_sum = (my_q + (my_q[MW-1] ? HALF - MW'(1) : HALF)) >>> FB;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.qx    <= point_x_i;
      s1_q.qy    <= point_y_i;
      s1_q.sx    <= sx_q;
      s1_q.sy    <= sy_q;
      s1_q.dx    <= DW'(ex_q) - DW'(sx_q);
      s1_q.dy    <= DW'(ey_q) - DW'(sy_q);
      s1_q.clamp <= clamp_to_segment_i;
      s1_q.neg   <= 1'b0;
      s1_q.zero  <= 1'b0;
      vx1_q      <= DW'(point_x_i) - DW'(sx_q);
      vy1_q      <= DW'(point_y_i) - DW'(sy_q);

      s2_q  <= s1_q;
      pxx_q <= PW'(s1_q.dx) * PW'(s1_q.dx);
      pyy_q <= PW'(s1_q.dy) * PW'(s1_q.dy);
      pvx_q <= PW'(vx1_q) * PW'(s1_q.dx);
      pvy_q <= PW'(vy1_q) * PW'(s1_q.dy);

      s3_q   <= s2_q;
      l2_3_q <= SW'(pxx_q) + SW'(pyy_q);
      dot_q  <= SW'(pvx_q) + SW'(pvy_q);

      s4_q      <= s4_d;
      l2_4_q    <= l2_3_q;
      mag_q     <= dot_q[SW-1] ? SW'(0) - dot_q : dot_q;

      s5_q   <= s4_q;
      l2_5_q <= l2_4_q;
      num_q  <= NW'({mag_q, {FB{1'b0}}}) + NW'(l2_4_q >> 1);

      s6_q <= sd;
      t_q  <= t_d;

      s7_q <= s6_q;
      mx_q <= MW'(s6_q.dx) * MW'(t_q);
      my_q <= MW'(s6_q.dy) * MW'(t_q);

      s8_q <= s7_q;
      rx_q <= rx_sum[RDW-1:0];
      ry_q <= ry_sum[RDW-1:0];

      qx9_q   <= s8_q.qx;
      qy9_q   <= s8_q.qy;
      n9_q.nx <= sat_coord(NSW'(s8_q.sx) + NSW'(rx_q));
      n9_q.ny <= sat_coord(NSW'(s8_q.sy) + NSW'(ry_q));

      n10_q <= n9_q;
      erx_q <= DW'(qx9_q) - DW'(n9_q.nx);
      ery_q <= DW'(qy9_q) - DW'(n9_q.ny);

      n11_q <= n10_q;
      sqx_q <= PW'(erx_q) * PW'(erx_q);
      sqy_q <= PW'(ery_q) * PW'(ery_q);
    end
  end

  psc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .num_i   (num_q),
    .den_i   (l2_5_q),
    .side_i  (s5_q),
    .valid_o (vd),
    .quo_o   (quo),
    .ovf_o   (ovf),
    .side_o  (sd)
  );

  psc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v11_q),
    .sq_i    (SW'(sqx_q) + SW'(sqy_q)),
    .near_i  (n11_q),
    .valid_o (vr),
    .dist_o  (dist_r),
    .near_o  (near_r)
  );

  // skid: catch the last stage when the output stalls, drain when released
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (vr && out_stall_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_dist_q <= dist_r;
      skid_near_q <= near_r;
    end
  end

  assign out_valid_o = skid_v_q | vr;
  assign near_x_o    = skid_v_q ? skid_near_q.nx : near_r.nx;
  assign near_y_o    = skid_v_q ? skid_near_q.ny : near_r.ny;
  assign distance_o  = skid_v_q ? skid_dist_q : dist_r;

  `PSC_ASSERT_IF(a_clamp_range, v6_q && s6_q.clamp, !t_q[TW-1] && t_q <= T_ONE)
  `PSC_ASSERT_IF(a_zero_len, v6_q && s6_q.zero, t_q == '0)
  `PSC_ASSERT_IF(a_skid_hold, skid_v_q && out_stall_i, ##1 (skid_v_q && !en))

endmodule

@@ tb/sv/point_segment_closest_point_checker.sv @@
`timescale 1ns / 100ps

module point_segment_closest_point_checker import psc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic signed [CW-1:0] point_x_i,
  input  logic signed [CW-1:0] point_y_i,
  input  logic                 clamp_to_segment_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [CW-1:0] near_x_i,
  input  logic signed [CW-1:0] near_y_i,
  input  logic [DISTW-1:0]     distance_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CIW-1:0]       cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic [DISTW-1:0]     distance;
  } projection_t;

  longint line_sx, line_sy, line_ex, line_ey;
  projection_t projections_q[$];

  assign pending_o = projections_q.size();

  function automatic longint clip_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // divide by 2^s, nearest, ties away from zero
  function automatic longint shift_round(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint root_round(longint s);
    longint r;
    r = longint'($floor($sqrt(real'(s))));
    while (r * r > s) r--;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic projection_t project_point(longint qx, longint qy, logic clamp);
    projection_t p;
    longint dx, dy, vx, vy, l2, dot, mag, q, t, nx, ny, ex, ey, d;
    dx = line_ex - line_sx;
    dy = line_ey - line_sy;
    vx = qx - line_sx;
    vy = qy - line_sy;
    l2 = dx * dx + dy * dy;
    dot = vx * dx + vy * dy;
    t = 0;
    if (l2 != 0) begin
      mag = (dot < 0) ? -dot : dot;
      q = ((mag << 16) + (l2 >> 1)) / l2;
      if (dot < 0) t = (q > (longint'(1) << 31)) ? -(longint'(1) << 31) : -q;
      else t = (q > (longint'(1) << 31) - 1) ? (longint'(1) << 31) - 1 : q;
    end
    if (clamp) begin
      if (t < 0) t = 0;
      if (t > 65536) t = 65536;
    end
    nx = clip_coord(line_sx + shift_round(dx * t, 16));
    ny = clip_coord(line_sy + shift_round(dy * t, 16));
    ex = qx - nx;
    ey = qy - ny;
    d = root_round(ex * ex + ey * ey);
    if (d > (1 << DISTW) - 1) d = (1 << DISTW) - 1;
    p.nx = nx[CW-1:0];
    p.ny = ny[CW-1:0];
    p.distance = d[DISTW-1:0];
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    projection_t exp_p;
    if (!rst_ni) begin
      line_sx <= 0;
      line_sy <= 0;
      line_ex <= 0;
      line_ey <= 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SX: line_sx <= longint'($signed(cfg_data_i));
          REG_SY: line_sy <= longint'($signed(cfg_data_i));
          REG_EX: line_ex <= longint'($signed(cfg_data_i));
          REG_EY: line_ey <= longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        projections_q.push_back(project_point(longint'(point_x_i), longint'(point_y_i),
                                              clamp_to_segment_i));
      if (out_valid_i && !out_stall_i) begin
        if (projections_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result word %0d %0d %0d",
                                           near_x_i, near_y_i, distance_i);
        end else begin
          exp_p = projections_q.pop_front();
          if (near_x_i !== exp_p.nx || near_y_i !== exp_p.ny
              || distance_i !== exp_p.distance)
          begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       exp_p.nx, exp_p.ny, exp_p.distance, near_x_i, near_y_i, distance_i);
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_point_segment_closest_point_unit.sv @@
`timescale 1ns / 100ps

module tb_point_segment_closest_point_unit;
  import psc_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [CW-1:0] point_x_i = '0;
  logic signed [CW-1:0] point_y_i = '0;
  logic                 clamp_to_segment_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [CW-1:0] near_x_o;
  logic signed [CW-1:0] near_y_o;
  logic [DISTW-1:0]     distance_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CIW-1:0]       cfg_index_i = '0;
  logic [CW-1:0]        cfg_data_i = '0;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  bit                   hold_off = 1'b0;
  bit                   stall_random = 1'b0;

  localparam int WATCHDOG = 20000;
  localparam int LATENCY = 65;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  point_segment_closest_point_unit i_dut (.*);

  point_segment_closest_point_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .point_x_i, .point_y_i,
    .clamp_to_segment_i, .out_valid_i(out_valid_o), .out_stall_i, .near_x_i(near_x_o),
    .near_y_i(near_y_o), .distance_i(distance_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern: quiet stretches, random stretches, long hold-offs
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (stall_random) out_stall_i <= ($urandom_range(0, 3) == 0);
    else out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_line(logic [CW-1:0] sx, logic [CW-1:0] sy,
                          logic [CW-1:0] ex, logic [CW-1:0] ey);
    write_reg(REG_SX, sx);
    write_reg(REG_SY, sy);
    write_reg(REG_EX, ex);
    write_reg(REG_EY, ey);
  endtask

  // hold valid across consecutive words; advance on acceptance
  task automatic send_word(logic [CW-1:0] x, logic [CW-1:0] y, logic c, bit keep);
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    clamp_to_segment_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    if (!keep) in_valid_i <= 1'b0;
  endtask

  // let the checker record the last accepted word before reading the count
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic send_random(int count, bit near_line);
    int burst;
    logic [CW-1:0] x, y;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if (n != 0 && $urandom_range(0, 2) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
      burst--;
      if (near_line) begin
        x = CW'($urandom_range(0, 2047) - 1024);
        y = CW'($urandom_range(0, 2047) - 1024);
      end else begin
        x = CW'($urandom);
        y = CW'($urandom);
      end
      send_word(x, y, 1'($urandom_range(0, 1)), burst != 0 && n != count - 1);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-length line after reset: nearest is the start point
    send_word(16'sd100, -16'sd50, 1'b0, 1'b1);
    send_word(16'sd100, -16'sd50, 1'b1, 1'b0);
    drain();

    set_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_word(16'h7fff, 16'h8000, 1'b0, 1'b1);
    send_word(16'h8000, 16'h7fff, 1'b1, 1'b1);
    send_word(16'h7fff, 16'h7fff, 1'b1, 1'b1);
    send_word(16'h8000, 16'h8000, 1'b0, 1'b1);
    send_word(16'hffff, 16'h0000, 1'b1, 1'b0);
    drain();

    // short line, far points: t and coordinates saturate
    set_line(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_word(16'h7fff, 16'h7fff, 1'b0, 1'b1);
    send_word(16'h8000, 16'h8000, 1'b0, 1'b1);
    send_word(16'h7fff, 16'h8000, 1'b1, 1'b1);
    send_word(16'h8000, 16'h0001, 1'b1, 1'b1);
    send_word(16'h5555, 16'haaaa, 1'b0, 1'b0);
    drain();
    // unknown index is ignored
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 4'hf;
    cfg_data_i <= 16'h1234;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    send_word(16'sd3, 16'sd7, 1'b0, 1'b0);
    drain();

    stall_random = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      set_line(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
      if (phase == 2) set_line(CW'($urandom_range(0, 255) - 128),
                               CW'($urandom_range(0, 255) - 128),
                               CW'($urandom_range(0, 255) - 128),
                               CW'($urandom_range(0, 255) - 128));
      if (phase == 5) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
          send_random(140, phase[0]);
        join
      end else send_random(140, phase[0]);
      if (phase == 3) stall_random = 1'b0;
      if (phase == 4) stall_random = 1'b1;
      drain();
    end

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/psc_pkg.sv
design/psc_div.sv
design/psc_sqrt.sv
design/point_segment_closest_point_unit.sv
tb/sv/point_segment_closest_point_checker.sv
tb/sv/tb_point_segment_closest_point_unit.sv
